/* design/ray_triangle_closest_hit_unit_defines.svh */
// assertion macros shared by the ray/triangle hit unit
`ifndef RAY_TRIANGLE_CLOSEST_HIT_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// implication checked in the same cycle
`define RTCH_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next cycle
`define RTCH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTCH_ASSERT_IMP(name, ante, cons, msg)
`define RTCH_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* design/rtch_pkg.sv */
`default_nettype none

package rtch_pkg;

    localparam int unsigned MAX_TRIANGLES_DEF = 65536;

    localparam int ACC_W   = 104;
    localparam int WIDE_W  = 67;
    localparam int EDGE_W  = 33;
    localparam int OPA_W   = 35;
    localparam int QUOT_W  = 31;
    localparam int BARY_W  = 17;
    localparam int IDX_W   = 16;
    localparam int CFG_W   = 32;
    localparam int STEP_W  = 6;
    localparam int MUL_STEPS = 48;

    // determinants below this magnitude count as degenerate
    localparam logic signed [ACC_W-1:0] DET_EPS_LSB = 104'sd282;

    typedef struct packed {
        logic signed [31:0] vertex_a_x;
        logic signed [31:0] vertex_a_y;
        logic signed [31:0] vertex_a_z;
        logic signed [31:0] vertex_b_x;
        logic signed [31:0] vertex_b_y;
        logic signed [31:0] vertex_b_z;
        logic signed [31:0] vertex_c_x;
        logic signed [31:0] vertex_c_y;
        logic signed [31:0] vertex_c_z;
        logic               last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic              any_hit;
        logic [QUOT_W-1:0] hit_distance;
        logic [BARY_W-1:0] hit_u;
        logic [BARY_W-1:0] hit_v;
        logic [IDX_W-1:0]  hit_index;
    } hit_out_t;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } cfg_index_t;

    // operand codes of the multiply-accumulate sequence
    typedef enum logic [4:0] {
        OP_DIR0, OP_DIR1, OP_DIR2,
        OP_AB0,  OP_AB1,  OP_AB2,
        OP_AC0,  OP_AC1,  OP_AC2,
        OP_TV0,  OP_TV1,  OP_TV2,
        OP_DAC0, OP_DAC1, OP_DAC2,
        OP_TAB0, OP_TAB1, OP_TAB2
    } opnd_t;

    typedef enum logic [3:0] {
        DST_DAC0, DST_DAC1, DST_DAC2,
        DST_TAB0, DST_TAB1, DST_TAB2,
        DST_DET,  DST_NU,   DST_NV,   DST_NT
    } dest_t;

    typedef struct packed {
        opnd_t a_sel;
        opnd_t b_sel;
        logic  sub;
        logic  first;
        logic  last;
        dest_t dest;
    } mac_op_t;

    typedef struct packed {
        logic  valid;
        logic  hi;
        logic  sub;
        logic  clr;
        logic  wr;
        dest_t dest;
    } mac_ctl_t;

    function automatic mac_op_t mk_op(input opnd_t a, input opnd_t b, input logic sub,
                                      input logic first, input logic last, input dest_t dest);
        mac_op_t r;
        r.a_sel = a;
        r.b_sel = b;
        r.sub   = sub;
        r.first = first;
        r.last  = last;
        r.dest  = dest;
        return r;
    endfunction

    // product schedule: dir x ac, det, nu, tv x ab, nv, nt
    function automatic mac_op_t prod_op(input logic [4:0] p);
        mac_op_t r;
        case (p)
            5'd0:    r = mk_op(OP_DIR1, OP_AC2, 1'b0, 1'b1, 1'b0, DST_DAC0);
            5'd1:    r = mk_op(OP_DIR2, OP_AC1, 1'b1, 1'b0, 1'b1, DST_DAC0);
            5'd2:    r = mk_op(OP_DIR2, OP_AC0, 1'b0, 1'b1, 1'b0, DST_DAC1);
            5'd3:    r = mk_op(OP_DIR0, OP_AC2, 1'b1, 1'b0, 1'b1, DST_DAC1);
            5'd4:    r = mk_op(OP_DIR0, OP_AC1, 1'b0, 1'b1, 1'b0, DST_DAC2);
            5'd5:    r = mk_op(OP_DIR1, OP_AC0, 1'b1, 1'b0, 1'b1, DST_DAC2);
            5'd6:    r = mk_op(OP_DAC0, OP_AB0, 1'b0, 1'b1, 1'b0, DST_DET);
            5'd7:    r = mk_op(OP_DAC1, OP_AB1, 1'b0, 1'b0, 1'b0, DST_DET);
            5'd8:    r = mk_op(OP_DAC2, OP_AB2, 1'b0, 1'b0, 1'b1, DST_DET);
            5'd9:    r = mk_op(OP_DAC0, OP_TV0, 1'b0, 1'b1, 1'b0, DST_NU);
            5'd10:   r = mk_op(OP_DAC1, OP_TV1, 1'b0, 1'b0, 1'b0, DST_NU);
            5'd11:   r = mk_op(OP_DAC2, OP_TV2, 1'b0, 1'b0, 1'b1, DST_NU);
            5'd12:   r = mk_op(OP_TV1,  OP_AB2, 1'b0, 1'b1, 1'b0, DST_TAB0);
            5'd13:   r = mk_op(OP_TV2,  OP_AB1, 1'b1, 1'b0, 1'b1, DST_TAB0);
            5'd14:   r = mk_op(OP_TV2,  OP_AB0, 1'b0, 1'b1, 1'b0, DST_TAB1);
            5'd15:   r = mk_op(OP_TV0,  OP_AB2, 1'b1, 1'b0, 1'b1, DST_TAB1);
            5'd16:   r = mk_op(OP_TV0,  OP_AB1, 1'b0, 1'b1, 1'b0, DST_TAB2);
            5'd17:   r = mk_op(OP_TV1,  OP_AB0, 1'b1, 1'b0, 1'b1, DST_TAB2);
            5'd18:   r = mk_op(OP_TAB0, OP_DIR0, 1'b0, 1'b1, 1'b0, DST_NV);
            5'd19:   r = mk_op(OP_TAB1, OP_DIR1, 1'b0, 1'b0, 1'b0, DST_NV);
            5'd20:   r = mk_op(OP_TAB2, OP_DIR2, 1'b0, 1'b0, 1'b1, DST_NV);
            5'd21:   r = mk_op(OP_TAB0, OP_AC0, 1'b0, 1'b1, 1'b0, DST_NT);
            5'd22:   r = mk_op(OP_TAB1, OP_AC1, 1'b0, 1'b0, 1'b0, DST_NT);
            5'd23:   r = mk_op(OP_TAB2, OP_AC2, 1'b0, 1'b0, 1'b1, DST_NT);
            default: r = mk_op(OP_DIR0, OP_DIR0, 1'b0, 1'b0, 1'b0, DST_DAC0);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/rtch_mac.sv */
`default_nettype none

module rtch_mac
    import rtch_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mac_ctl_t                 ctl_in,
    input  wire logic signed [OPA_W-1:0]  opa,
    input  wire logic signed [EDGE_W-1:0] opb,
    output logic                          wr_valid,
    output dest_t                         wr_dest,
    output logic signed [ACC_W-1:0]       wr_value
);

    localparam int PROD_W = OPA_W + EDGE_W;
    localparam int HI_SHIFT = WIDE_W - EDGE_W;

    mac_ctl_t                  ctl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   base;

    // multiplier stage
    assign prod_next = opa * opb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
        prod_reg <= prod_next;
    end

    // accumulate stage, high partial product weighted by the split point
    always_comb begin
        term = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (ctl_reg.hi) begin
            term = term <<< HI_SHIFT;
        end
        base = ctl_reg.clr ? '0 : acc_reg;
        acc_next = ctl_reg.sub ? (base - term) : (base + term);
    end

    always_ff @(posedge aclk) begin
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign wr_valid = ctl_reg.valid && ctl_reg.wr;
    assign wr_dest  = ctl_reg.dest;
    assign wr_value = acc_next;

endmodule

`default_nettype wire

/* design/rtch_div.sv */
`default_nettype none

`include "ray_triangle_closest_hit_unit_defines.svh"

module rtch_div
    import rtch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              wide_mode,
    input  wire logic [ACC_W-1:0]  num,
    input  wire logic [ACC_W-1:0]  den,
    output logic                   done,
    output logic [QUOT_W-1:0]      quot
);

    localparam int FRAC = 16;
    localparam int CNT_W = 5;

    logic                busy_reg;
    logic                done_reg;
    logic                sat_reg;
    logic                wide_reg;
    logic [ACC_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]   sh_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ACC_W:0]      trial;
    logic                ge;
    logic [ACC_W-1:0]    rem_wide_init;
    logic                sat_hit;

    // leading part of num * 2^16 that is above the quotient bits
    assign rem_wide_init = num >> (QUOT_W - FRAC);
    assign sat_hit = rem_wide_init >= den;

    // one restoring step per cycle
    assign trial = {rem_reg, sh_reg[QUOT_W-1]} - {1'b0, den};
    assign ge = !trial[ACC_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                wide_reg <= wide_mode;
                q_reg    <= '0;
                if (wide_mode) begin
                    rem_reg <= rem_wide_init;
                    sh_reg  <= {num[QUOT_W-FRAC-1:0], {FRAC{1'b0}}};
                    cnt_reg <= CNT_W'(QUOT_W);
                    sat_reg <= sat_hit;
                    busy_reg <= !sat_hit;
                    done_reg <= sat_hit;
                end else begin
                    rem_reg <= num >> 1;
                    sh_reg  <= {num[0], {(QUOT_W-1){1'b0}}};
                    cnt_reg <= CNT_W'(BARY_W);
                    sat_reg <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= ge ? trial[ACC_W-1:0] : {rem_reg[ACC_W-2:0], sh_reg[QUOT_W-1]};
                sh_reg  <= {sh_reg[QUOT_W-2:0], 1'b0};
                q_reg   <= {q_reg[QUOT_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? {QUOT_W{1'b1}} : q_reg;

    `RTCH_ASSERT_IMP(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `RTCH_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "divider done held two cycles")
    `RTCH_ASSERT_IMP(a_sat_wide, done_reg && sat_reg, wide_reg, "saturation outside distance")

endmodule

`default_nettype wire

/* design/ray_triangle_closest_hit_unit.sv */
// Closest-hit ray/triangle unit.
// Write the ray origin and direction (signed Q16.16) through the cfg port while idle.
// Each s_ item is one triangle (three vertices); last_triangle closes the set.
// Per triangle, one shared 35x33 multiplier with a 104-bit accumulator runs 48 steps
// for the cross products, the determinant and the u, v, t numerators; a one-bit-per-cycle
// restoring divider then forms t (31 steps) and, for a new closest hit, u and v
// (17 steps each). s_ready is high only between items.
// After the last triangle of a set one m_ item carries any_hit, distance, u, v and
// the index of the winning triangle, and the running state clears for the next set.
// The result sits in an output register: the next set can start while it waits,
// and a stalled receiver only holds the block once the next set's result is due.
// Reset clears the ray registers to zero, the running best and the triangle count.
`default_nettype none

`include "ray_triangle_closest_hit_unit_defines.svh"

module ray_triangle_closest_hit_unit
    import rtch_pkg::*;
#(
    parameter int unsigned MAX_TRIANGLES = MAX_TRIANGLES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tri_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hit_out_t              m_data
);

    localparam int unsigned IDX_LIMIT =
        (MAX_TRIANGLES - 1 < 65535) ? (MAX_TRIANGLES - 1) : 65535;
    localparam logic [IDX_W-1:0] IDX_LIMIT_V = IDX_W'(IDX_LIMIT);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL    = 9'b000000010,
        ST_DRAIN  = 9'b000000100,
        ST_NORM   = 9'b000001000,
        ST_TEST   = 9'b000010000,
        ST_DIV_T  = 9'b000100000,
        ST_DIV_U  = 9'b001000000,
        ST_DIV_V  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // ray registers
    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];

    // triangle operands and products
    logic signed [EDGE_W-1:0] ab_reg [3];
    logic signed [EDGE_W-1:0] ac_reg [3];
    logic signed [EDGE_W-1:0] tv_reg [3];
    logic signed [WIDE_W-1:0] dac_reg [3];
    logic signed [WIDE_W-1:0] tab_reg [3];
    logic signed [ACC_W-1:0]  det_reg;
    logic signed [ACC_W-1:0]  nu_reg;
    logic signed [ACC_W-1:0]  nv_reg;
    logic signed [ACC_W-1:0]  nt_reg;
    logic                     last_reg;

    // running best of the set
    logic [31:0]        best_dist_reg;
    logic [BARY_W-1:0]  best_u_reg;
    logic [BARY_W-1:0]  best_v_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               hit_seen_reg;
    logic [IDX_W-1:0]   tri_count_reg;
    logic [QUOT_W-1:0]  cand_dist_reg;
    logic [BARY_W-1:0]  cand_u_reg;

    logic               m_valid_reg;
    hit_out_t           m_data_reg;

    logic [STEP_W-1:0]  step_reg;
    mac_op_t            op;
    mac_ctl_t           mac_ctl;
    logic signed [WIDE_W-1:0] a_wide;
    logic signed [EDGE_W-1:0] b_narrow;
    logic signed [OPA_W-1:0]  opa;
    logic               wr_valid;
    dest_t              wr_dest;
    logic signed [ACC_W-1:0]  wr_value;

    logic               div_start;
    logic               div_wide;
    logic [ACC_W-1:0]   div_num;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    logic               miss;
    logic signed [ACC_W-1:0] uv_sum;
    logic               accept;
    logic               out_free;
    logic               improve;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign improve  = {1'b0, div_quot} < best_dist_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                CFG_DIR_X:    dir_reg[0] <= cfg_wdata;
                CFG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                CFG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    assign op = prod_op(step_reg[STEP_W-1:1]);

    always_comb begin
        case (op.a_sel)
            OP_DIR0: a_wide = WIDE_W'(dir_reg[0]);
            OP_DIR1: a_wide = WIDE_W'(dir_reg[1]);
            OP_DIR2: a_wide = WIDE_W'(dir_reg[2]);
            OP_TV0:  a_wide = WIDE_W'(tv_reg[0]);
            OP_TV1:  a_wide = WIDE_W'(tv_reg[1]);
            OP_TV2:  a_wide = WIDE_W'(tv_reg[2]);
            OP_DAC0: a_wide = dac_reg[0];
            OP_DAC1: a_wide = dac_reg[1];
            OP_DAC2: a_wide = dac_reg[2];
            OP_TAB0: a_wide = tab_reg[0];
            OP_TAB1: a_wide = tab_reg[1];
            OP_TAB2: a_wide = tab_reg[2];
            default: a_wide = '0;
        endcase
        case (op.b_sel)
            OP_DIR0: b_narrow = EDGE_W'(dir_reg[0]);
            OP_DIR1: b_narrow = EDGE_W'(dir_reg[1]);
            OP_DIR2: b_narrow = EDGE_W'(dir_reg[2]);
            OP_AB0:  b_narrow = ab_reg[0];
            OP_AB1:  b_narrow = ab_reg[1];
            OP_AB2:  b_narrow = ab_reg[2];
            OP_AC0:  b_narrow = ac_reg[0];
            OP_AC1:  b_narrow = ac_reg[1];
            OP_AC2:  b_narrow = ac_reg[2];
            OP_TV0:  b_narrow = tv_reg[0];
            OP_TV1:  b_narrow = tv_reg[1];
            OP_TV2:  b_narrow = tv_reg[2];
            default: b_narrow = '0;
        endcase
        // low half unsigned, high half signed
        if (step_reg[0]) begin
            opa = {{(OPA_W-EDGE_W){a_wide[WIDE_W-1]}}, a_wide[WIDE_W-1:WIDE_W-EDGE_W]};
        end else begin
            opa = {1'b0, a_wide[WIDE_W-EDGE_W-1:0]};
        end
        mac_ctl.valid = (state_reg == ST_MUL);
        mac_ctl.hi    = step_reg[0];
        mac_ctl.sub   = op.sub;
        mac_ctl.clr   = op.first && !step_reg[0];
        mac_ctl.wr    = op.last && step_reg[0];
        mac_ctl.dest  = op.dest;
    end

    rtch_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (mac_ctl),
        .opa      (opa),
        .opb      (b_narrow),
        .wr_valid (wr_valid),
        .wr_dest  (wr_dest),
        .wr_value (wr_value)
    );

    // hit tests on sign-corrected numerators
    assign uv_sum = nu_reg + nv_reg;
    assign miss = (det_reg < DET_EPS_LSB) || nu_reg[ACC_W-1] || (det_reg < nu_reg)
               || nv_reg[ACC_W-1] || (det_reg < uv_sum) || nt_reg[ACC_W-1];

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_wide  = 1'b0;
        div_num   = nt_reg;
        case (state_reg)
            ST_TEST: begin
                div_start = !miss;
                div_wide  = 1'b1;
            end
            ST_DIV_T: begin
                div_start = div_done && improve;
                div_num   = nu_reg;
            end
            ST_DIV_U: begin
                div_start = div_done;
                div_num   = nv_reg;
            end
            default: ;
        endcase
    end

    rtch_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .wide_mode (div_wide),
        .num       (div_num),
        .den       (det_reg),
        .done      (div_done),
        .quot      (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_MUL;
            ST_MUL:    if (step_reg == STEP_W'(MUL_STEPS - 1)) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_NORM;
            ST_NORM:   state_next = ST_TEST;
            ST_TEST:   state_next = miss ? ST_FINISH : ST_DIV_T;
            ST_DIV_T:  if (div_done) state_next = improve ? ST_DIV_U : ST_FINISH;
            ST_DIV_U:  if (div_done) state_next = ST_DIV_V;
            ST_DIV_V:  if (div_done) state_next = ST_FINISH;
            ST_FINISH: if (!last_reg || out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MUL) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    // edge vectors at accept, products from the accumulator, sign fix
    always_ff @(posedge aclk) begin
        if (accept) begin
            ab_reg[0] <= EDGE_W'(s_data.vertex_b_x) - EDGE_W'(s_data.vertex_a_x);
            ab_reg[1] <= EDGE_W'(s_data.vertex_b_y) - EDGE_W'(s_data.vertex_a_y);
            ab_reg[2] <= EDGE_W'(s_data.vertex_b_z) - EDGE_W'(s_data.vertex_a_z);
            ac_reg[0] <= EDGE_W'(s_data.vertex_c_x) - EDGE_W'(s_data.vertex_a_x);
            ac_reg[1] <= EDGE_W'(s_data.vertex_c_y) - EDGE_W'(s_data.vertex_a_y);
            ac_reg[2] <= EDGE_W'(s_data.vertex_c_z) - EDGE_W'(s_data.vertex_a_z);
            tv_reg[0] <= EDGE_W'(org_reg[0]) - EDGE_W'(s_data.vertex_a_x);
            tv_reg[1] <= EDGE_W'(org_reg[1]) - EDGE_W'(s_data.vertex_a_y);
            tv_reg[2] <= EDGE_W'(org_reg[2]) - EDGE_W'(s_data.vertex_a_z);
            last_reg  <= s_data.last_triangle;
        end
        if (wr_valid) begin
            case (wr_dest)
                DST_DAC0: dac_reg[0] <= wr_value[WIDE_W-1:0];
                DST_DAC1: dac_reg[1] <= wr_value[WIDE_W-1:0];
                DST_DAC2: dac_reg[2] <= wr_value[WIDE_W-1:0];
                DST_TAB0: tab_reg[0] <= wr_value[WIDE_W-1:0];
                DST_TAB1: tab_reg[1] <= wr_value[WIDE_W-1:0];
                DST_TAB2: tab_reg[2] <= wr_value[WIDE_W-1:0];
                DST_DET:  det_reg <= wr_value;
                DST_NU:   nu_reg  <= wr_value;
                DST_NV:   nv_reg  <= wr_value;
                DST_NT:   nt_reg  <= wr_value;
                default: ;
            endcase
        end
        if (state_reg == ST_NORM && det_reg[ACC_W-1]) begin
            det_reg <= -det_reg;
            nu_reg  <= -nu_reg;
            nv_reg  <= -nv_reg;
            nt_reg  <= -nt_reg;
        end
        if (state_reg == ST_DIV_T && div_done) begin
            cand_dist_reg <= div_quot;
        end
        if (state_reg == ST_DIV_U && div_done) begin
            cand_u_reg <= div_quot[BARY_W-1:0];
        end
    end

    // closest-hit bookkeeping and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= '1;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            best_idx_reg  <= '0;
            hit_seen_reg  <= 1'b0;
            tri_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == ST_FINISH && last_reg)) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DIV_T && div_done) begin
                hit_seen_reg <= 1'b1;
            end
            if (state_reg == ST_DIV_V && div_done) begin
                best_dist_reg <= {1'b0, cand_dist_reg};
                best_u_reg    <= cand_u_reg;
                best_v_reg    <= div_quot[BARY_W-1:0];
                best_idx_reg  <= tri_count_reg;
            end
            if (state_reg == ST_FINISH) begin
                if (!last_reg) begin
                    if (tri_count_reg < IDX_LIMIT_V) begin
                        tri_count_reg <= tri_count_reg + 1'b1;
                    end
                end else if (out_free) begin
                    m_valid_reg <= 1'b1;
                    m_data_reg.any_hit      <= hit_seen_reg;
                    m_data_reg.hit_distance <= hit_seen_reg ? best_dist_reg[QUOT_W-1:0] : '0;
                    m_data_reg.hit_u        <= hit_seen_reg ? best_u_reg : '0;
                    m_data_reg.hit_v        <= hit_seen_reg ? best_v_reg : '0;
                    m_data_reg.hit_index    <= hit_seen_reg ? best_idx_reg : '0;
                    best_dist_reg <= '1;
                    best_u_reg    <= '0;
                    best_v_reg    <= '0;
                    best_idx_reg  <= '0;
                    hit_seen_reg  <= 1'b0;
                    tri_count_reg <= '0;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RTCH_ASSERT_IMP(a_clear_on_result, $rose(m_valid_reg), tri_count_reg == '0,
        "triangle count not cleared with result")
    `RTCH_ASSERT_IMP(a_miss_zero, m_valid_reg && !m_data_reg.any_hit,
        m_data_reg.hit_distance == '0 && m_data_reg.hit_u == '0
        && m_data_reg.hit_v == '0 && m_data_reg.hit_index == '0,
        "miss result carries nonzero fields")
    `RTCH_ASSERT_IMP(a_bary_range, m_valid_reg && m_data_reg.any_hit,
        m_data_reg.hit_u <= 17'h10000 && m_data_reg.hit_v <= 17'h10000,
        "barycentric out of range")

endmodule

`default_nettype wire
